// ----- sv/sril_pkg.sv -----
// Constants and lookup tables shared by the sky region index lookup block.
`default_nettype none
package sril_pkg;

  // Angles are in units of 0.01 arcsecond.
  localparam logic [26:0] FULL_CIRCLE = 27'd129600000;
  localparam logic [24:0] BAND_SPAN   = 25'd2700000;
  localparam logic [9:0]  SOUTH_SHIFT = 10'd366;

  // Band span divided into two, three and four rows of small regions.
  localparam logic [24:0] HALF_BAND    = 25'd1350000;
  localparam logic [24:0] THIRD_BAND   = 25'd900000;
  localparam logic [24:0] QUARTER_BAND = 25'd675000;

  // ceil(2^32 / (FULL_CIRCLE / 512)) for the quotient estimate of ra * nl.
  localparam logic [14:0] RECIP_C = 15'd16968;
  // ceil(2^31 / 3) for the division of the corner by three.
  localparam logic [29:0] RECIP_3 = 30'd715827883;

  localparam int BAND_NUM = 12;

  localparam logic [5:0] BAND_COUNT [BAND_NUM] =
    '{6'd48, 6'd47, 6'd45, 6'd43, 6'd40, 6'd36, 6'd32, 6'd27, 6'd21, 6'd15, 6'd9, 6'd3};
  localparam logic [8:0] BAND_FIRST [BAND_NUM] =
    '{9'd1, 9'd49, 9'd96, 9'd141, 9'd184, 9'd224, 9'd260, 9'd292, 9'd319, 9'd340,
      9'd355, 9'd364};
  localparam logic [24:0] BAND_BASE [BAND_NUM] =
    '{25'd0, 25'd2700000, 25'd5400000, 25'd8100000, 25'd10800000, 25'd13500000,
      25'd16200000, 25'd18900000, 25'd21600000, 25'd24300000, 25'd27000000,
      25'd29700000};
  // Quotient and remainder of FULL_CIRCLE by the band's region count.
  localparam logic [25:0] BAND_Q1 [BAND_NUM] =
    '{26'd2700000, 26'd2757446, 26'd2880000, 26'd3013953, 26'd3240000, 26'd3600000,
      26'd4050000, 26'd4800000, 26'd6171428, 26'd8640000, 26'd14400000, 26'd43200000};
  localparam logic [5:0] BAND_R1 [BAND_NUM] =
    '{6'd0, 6'd38, 6'd0, 6'd21, 6'd0, 6'd0, 6'd0, 6'd0, 6'd12, 6'd0, 6'd0, 6'd0};
  // ceil(2^21 / count), needed only where the remainder above is not zero.
  localparam logic [16:0] BAND_M1 [BAND_NUM] =
    '{17'd0, 17'd44621, 17'd0, 17'd48771, 17'd0, 17'd0, 17'd0, 17'd0, 17'd99865,
      17'd0, 17'd0, 17'd0};

  // Run-length form of the subdivision table over large regions 1 to 732.
  localparam int RUN_NUM = 80;

  localparam logic [2:0] RUN_NSUB [RUN_NUM] = '{
    3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd4,
    3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd4,
    3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd3, 3'd4,
    3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd4,
    3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd2,
    3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4};

  localparam logic [4:0] RUN_CNT [RUN_NUM] = '{
    5'd9, 5'd9, 5'd12, 5'd14, 5'd12, 5'd9, 5'd13, 5'd14, 5'd9, 5'd10,
    5'd5, 5'd3, 5'd6, 5'd13, 5'd6, 5'd11, 5'd4, 5'd5, 5'd5, 5'd13,
    5'd1, 5'd14, 5'd4, 5'd4, 5'd6, 5'd24, 5'd4, 5'd4, 5'd5, 5'd21,
    5'd5, 5'd3, 5'd5, 5'd18, 5'd10, 5'd15, 5'd8, 5'd11, 5'd6, 5'd7,
    5'd3, 5'd6,
    5'd2, 5'd2, 5'd5, 5'd10, 5'd10, 5'd15, 5'd5, 5'd4, 5'd5, 5'd10,
    5'd8, 5'd15, 5'd5, 5'd4, 5'd4, 5'd11, 5'd5, 5'd16, 5'd5, 5'd4,
    5'd4, 5'd30, 5'd5, 5'd3, 5'd5, 5'd27, 5'd12, 5'd25, 5'd10, 5'd22,
    5'd9, 5'd19, 5'd6, 5'd15, 5'd5, 5'd11, 5'd1, 5'd12};

  typedef logic [RUN_NUM-1:0][9:0]  run_start_t;
  typedef logic [RUN_NUM-1:0][13:0] run_base_t;

  // Zero-based large region at which each run begins.
  function automatic run_start_t calc_run_start();
    run_start_t s;
    logic [9:0] acc;
    acc = 10'd0;
    for (int i = 0; i < RUN_NUM; i++) begin
      s[i] = acc;
      acc  = acc + 10'(RUN_CNT[i]);
    end
    return s;
  endfunction

  // First small region number of each run.
  function automatic run_base_t calc_run_base();
    run_base_t b;
    logic [13:0] acc;
    acc = 14'd1;
    for (int i = 0; i < RUN_NUM; i++) begin
      b[i] = acc;
      acc  = acc + 14'(RUN_CNT[i]) * 14'(RUN_NSUB[i]) * 14'(RUN_NSUB[i]);
    end
    return b;
  endfunction

  localparam run_start_t RUN_START = calc_run_start();
  localparam run_base_t  RUN_BASE  = calc_run_base();

endpackage
`default_nettype wire

// ----- sv/sky_region_index_lookup_core.sv -----
// Pipelined lookup of the catalog small region and its corner for one sky position.
//
// Input channel: in_valid_i with ra_angle_i (unsigned) and dec_angle_i (signed), in
// units of 0.01 arcsecond. A word is taken at a rising edge with in_valid_i high and
// in_stall_o low. Output channel: out_valid_o with the region fields, taken at an edge
// with out_valid_o high and out_stall_i low. Each input word gives one output word.
//
// The work runs through fourteen register stages: angle folding, band search,
// the ra * count product, a reciprocal quotient estimate, the remainder of the estimate,
// its correction with the large region sum, a compare against every run of the
// subdivision table, the run select, the run read, the small-region steps, the region
// number with the declination corner, and three stages for the corner right ascension.
// A word shows on the output once it has passed every stage and, without a stall, leaves at the next edge.
// One word can enter in every cycle while in_stall_o is low, so the rate is one per clock.
//
// Each stage holds a valid bit. A stage loads whenever it is empty or the stage after
// it moves, so bubbles close up while the receiver stalls and the input keeps taking
// words until every stage is full; then in_stall_o rises. A stalled output word holds.
// The asynchronous reset clears all valid bits; the data registers are not reset.
`default_nettype none
module sky_region_index_lookup_core
  import sril_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [27:0] ra_angle_i,
  input  wire logic signed [25:0] dec_angle_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    south_o,
  output logic             [3:0]  dec_band_o,
  output logic             [9:0]  large_region_o,
  output logic             [13:0] region_id_o,
  output logic             [26:0] ra_origin_o,
  output logic             [24:0] dec_origin_o
);

  localparam int NSTG = 14;

  localparam logic signed [26:0] QUARTER_S   = 27'sd32400000;
  localparam logic signed [26:0] HALF_FOLD_S = 27'sd64799999;

  // Everything one word carries down the pipeline; each stage fills in its part.
  typedef struct packed {
    logic [26:0]        ra;
    logic               south;
    logic [24:0]        d;
    logic [3:0]         band;
    logic [21:0]        dd;
    logic [32:0]        prod;
    logic [6:0]         qe;
    logic [27:0]        rem;
    logic [5:0]         rareg;
    logic [26:0]        rrem;
    logic [9:0]         lreg;
    logic [RUN_NUM-1:0] ge;
    logic [6:0]         idx;
    logic [2:0]         nsub;
    logic [4:0]         off;
    logic [13:0]        base;
    logic [13:0]        first;
    logic [1:0]         nsmra;
    logic [1:0]         nsmdec;
    logic [13:0]        id;
    logic [7:0]         t;
    logic [13:0]        y;
    logic [24:0]        dec0;
    logic [7:0]         f;
    logic [28:0]        tq;
    logic [28:0]        acc;
    logic [26:0]        ra0;
  } item_t;

  item_t            pipe_q [NSTG];
  item_t            pipe_d [NSTG];
  logic [NSTG-1:0]  valid_q;
  logic [NSTG-1:0]  valid_d;
  logic [NSTG-1:0]  en;

  // A stage may load when it is empty or when its word moves on in the same cycle.
  always_comb begin
    en[NSTG-1] = !valid_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = in_valid_i;
    for (int k = 1; k < NSTG; k++) begin
      valid_d[k] = valid_q[k-1];
    end
  end

  assign in_stall_o = !en[0];

  always_comb begin
    logic        [27:0]   r1;
    logic        [27:0]   r2;
    logic signed [26:0]   dx;
    logic signed [26:0]   df;
    logic signed [26:0]   dmag;
    logic        [3:0]    bcnt;
    logic        [23:0]   xs;
    logic        [38:0]   pm;
    logic        [33:0]   qc;
    logic        [34:0]   rem35;
    logic        [9:0]    left;
    logic        [RUN_NUM:0] gx;
    logic        [6:0]    iv;
    logic        [4:0]    sq;
    logic        [28:0]   pr;
    logic        [24:0]   pd;
    logic        [24:0]   step;
    logic        [30:0]   fm;
    logic        [33:0]   tqm;
    logic        [58:0]   am;

    pipe_d[0] = '0;
    for (int k = 1; k < NSTG; k++) begin
      pipe_d[k] = pipe_q[k-1];
    end

    // Stage 0: wrap the right ascension and fold the declination into (-90, 90).
    r1 = (ra_angle_i >= 28'(FULL_CIRCLE)) ? ra_angle_i - 28'(FULL_CIRCLE) : ra_angle_i;
    r2 = (r1 >= 28'(FULL_CIRCLE)) ? r1 - 28'(FULL_CIRCLE) : r1;
    pipe_d[0].ra = r2[26:0];
    dx = $signed({dec_angle_i[25], dec_angle_i});
    if (dx <= -QUARTER_S) begin
      df = -HALF_FOLD_S - dx;
    end else if (dx >= QUARTER_S) begin
      df = HALF_FOLD_S - dx;
    end else begin
      df = dx;
    end
    pipe_d[0].south = df[26];
    dmag = df[26] ? -df : df;
    pipe_d[0].d = dmag[24:0];

    // Stage 1: 7.5-degree band and the offset inside it.
    bcnt = 4'd0;
    for (int j = 1; j < BAND_NUM; j++) begin
      bcnt = bcnt + 4'(pipe_q[0].d >= BAND_BASE[j]);
    end
    pipe_d[1].band = bcnt;
    pipe_d[1].dd   = 22'(pipe_q[0].d - BAND_BASE[bcnt]);

    // Stage 2: right ascension scaled by the band's region count.
    pipe_d[2].prod = 33'(pipe_q[1].ra) * 33'(BAND_COUNT[pipe_q[1].band]);

    // Stage 3: quotient estimate by reciprocal; it is exact or one too large.
    xs = pipe_q[2].prod[32:9];
    pm = 39'(xs) * 39'(RECIP_C);
    pipe_d[3].qe = pm[38:32];

    // Stage 4: remainder of the estimate.
    qc    = 34'(pipe_q[3].qe) * 34'(FULL_CIRCLE);
    rem35 = {2'b00, pipe_q[3].prod} - {1'b0, qc};
    pipe_d[4].rem = rem35[27:0];

    // Stage 5: correct the quotient and form the large region number.
    if (pipe_q[4].rem[27]) begin
      pipe_d[5].rareg = 6'(pipe_q[4].qe - 7'd1);
      pipe_d[5].rrem  = 27'(pipe_q[4].rem + 28'(FULL_CIRCLE));
    end else begin
      pipe_d[5].rareg = pipe_q[4].qe[5:0];
      pipe_d[5].rrem  = pipe_q[4].rem[26:0];
    end
    pipe_d[5].lreg = 10'(BAND_FIRST[pipe_q[4].band]) + 10'(pipe_d[5].rareg)
                   + (pipe_q[4].south ? SOUTH_SHIFT : 10'd0);

    // Stage 6: compare against the start of every run.
    left = pipe_q[5].lreg - 10'd1;
    for (int i = 0; i < RUN_NUM; i++) begin
      pipe_d[6].ge[i] = (left >= RUN_START[i]);
    end

    // Stage 7: the run is the last one whose start is not above the region.
    gx = {1'b0, pipe_q[6].ge};
    iv = 7'd0;
    for (int i = 0; i < RUN_NUM; i++) begin
      if (gx[i] && !gx[i+1]) begin
        iv = iv | 7'(i);
      end
    end
    pipe_d[7].idx = iv;

    // Stage 8: read the run.
    pipe_d[8].nsub = RUN_NSUB[pipe_q[7].idx];
    pipe_d[8].off  = 5'(pipe_q[7].lreg - 10'd1 - RUN_START[pipe_q[7].idx]);
    pipe_d[8].base = RUN_BASE[pipe_q[7].idx];

    // Stage 9: first small region and the steps inside the large region.
    sq = 5'(6'(pipe_q[8].nsub) * 6'(pipe_q[8].nsub));
    pipe_d[9].first = pipe_q[8].base + 14'(10'(pipe_q[8].off) * 10'(sq));
    pr = 29'(pipe_q[8].rrem) * 29'(pipe_q[8].nsub);
    if (pr >= 29'(FULL_CIRCLE) * 29'd3) begin
      pipe_d[9].nsmra = 2'd3;
    end else if (pr >= 29'(FULL_CIRCLE) * 29'd2) begin
      pipe_d[9].nsmra = 2'd2;
    end else if (pr >= 29'(FULL_CIRCLE)) begin
      pipe_d[9].nsmra = 2'd1;
    end else begin
      pipe_d[9].nsmra = 2'd0;
    end
    pd = 25'(pipe_q[8].dd) * 25'(pipe_q[8].nsub);
    if (pd >= BAND_SPAN * 25'd3) begin
      pipe_d[9].nsmdec = 2'd3;
    end else if (pd >= BAND_SPAN * 25'd2) begin
      pipe_d[9].nsmdec = 2'd2;
    end else if (pd >= BAND_SPAN) begin
      pipe_d[9].nsmdec = 2'd1;
    end else begin
      pipe_d[9].nsmdec = 2'd0;
    end

    // Stage 10: region number, declination corner, and the corner numerator.
    pipe_d[10].id = pipe_q[9].first + 14'(4'(pipe_q[9].nsub) * 4'(pipe_q[9].nsmdec))
                  + 14'(pipe_q[9].nsmra);
    pipe_d[10].t  = 8'(8'(pipe_q[9].rareg) * 8'(pipe_q[9].nsub)) + 8'(pipe_q[9].nsmra);
    pipe_d[10].y  = 14'(pipe_d[10].t) * 14'(BAND_R1[pipe_q[9].band]);
    case (pipe_q[9].nsub)
      3'd2:    step = HALF_BAND;
      3'd3:    step = THIRD_BAND;
      default: step = QUARTER_BAND;
    endcase
    pipe_d[10].dec0 = BAND_BASE[pipe_q[9].band] + 25'(pipe_q[9].nsmdec) * step;

    // Stage 11: t * FULL_CIRCLE / count as quotient part plus remainder part.
    fm = 31'(pipe_q[10].y) * 31'(BAND_M1[pipe_q[10].band]);
    pipe_d[11].f = fm[28:21];
    tqm = 34'(pipe_q[10].t) * 34'(BAND_Q1[pipe_q[10].band]);
    pipe_d[11].tq = tqm[28:0];

    // Stage 12: sum of both parts.
    pipe_d[12].acc = pipe_q[11].tq + 29'(pipe_q[11].f);

    // Stage 13: divide by the subdivision count.
    am = 59'(pipe_q[12].acc) * 59'(RECIP_3);
    case (pipe_q[12].nsub)
      3'd2:    pipe_d[13].ra0 = pipe_q[12].acc[27:1];
      3'd4:    pipe_d[13].ra0 = pipe_q[12].acc[28:2];
      default: pipe_d[13].ra0 = am[57:31];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign out_valid_o    = valid_q[NSTG-1];
  assign south_o        = pipe_q[NSTG-1].south;
  assign dec_band_o     = pipe_q[NSTG-1].band;
  assign large_region_o = pipe_q[NSTG-1].lreg;
  assign region_id_o    = pipe_q[NSTG-1].id;
  assign ra_origin_o    = pipe_q[NSTG-1].ra0;
  assign dec_origin_o   = pipe_q[NSTG-1].dec0;

endmodule
`default_nettype wire

// ----- sv/sril_checker.sv -----
// Port-level assertions for the sky region index lookup core, with its bind.
`default_nettype none
module sril_checker
  import sril_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic        [27:0] ra_angle_i,
  input wire logic signed [25:0] dec_angle_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               south_o,
  input wire logic        [3:0]  dec_band_o,
  input wire logic        [9:0]  large_region_o,
  input wire logic        [13:0] region_id_o,
  input wire logic        [26:0] ra_origin_o,
  input wire logic        [24:0] dec_origin_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(region_id_o)
      && $stable(ra_origin_o) && $stable(dec_origin_o))
    else $error("stalled output word changed");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dec_band_o <= 4'd11 && ra_origin_o < FULL_CIRCLE && region_id_o != 14'd0)
    else $error("output field out of range");

  a_south: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && south_o |-> large_region_o > SOUTH_SHIFT)
    else $error("southern word without southern large region");

  a_north: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !south_o |-> large_region_o <= SOUTH_SHIFT && large_region_o != 10'd0)
    else $error("northern word with southern large region");

endmodule

bind sky_region_index_lookup_core sril_checker u_sril_checker (.*);
`default_nettype wire
